// ===== hdl/readout_word_channel_deframer_unit_macros.svh =====
// assertion helpers used by the deframer result buffer
`ifndef READOUT_WORD_CHANNEL_DEFRAMER_UNIT_MACROS_SVH
`define READOUT_WORD_CHANNEL_DEFRAMER_UNIT_MACROS_SVH

// condition holds at every edge out of reset
`define RWCD_ASSERT(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// same-cycle implication
`define RWCD_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define RWCD_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/rwcd_pkg.sv =====
package rwcd_pkg;

   localparam int NumChannels = 16;
   localparam int ChanSelW    = (NumChannels > 1) ? $clog2(NumChannels) : 1;

   localparam logic [31:0] RegMarker  = 32'h5500_0000;
   localparam logic [3:0]  TagTrigger = 4'h8;
   localparam logic [3:0]  TagTdcLo   = 4'h1;
   localparam logic [3:0]  TagTdcHi   = 4'h4;
   localparam logic [3:0]  TagUserK   = 4'h1;

   localparam logic [7:0]  KBoth  = 8'd0;
   localparam logic [7:0]  KData1 = 8'd1;
   localparam logic [7:0]  KData0 = 8'd2;

   localparam logic        CsrChipType   = 1'b0;
   localparam logic        CsrChanEnable = 1'b1;

   typedef struct packed {
      logic [31:0] word;
      logic        is_register;
      logic        error;
   } rsp_slot_type;

   typedef struct packed {
      logic [2:0]         count;
      logic [3:0]         channel;
      rsp_slot_type [3:0] slots;
   } rsp_set_type;

   typedef struct packed {
      logic [1:0]  half_count;
      logic        frame_mode;
      logic [47:0] held_halves;
   } chan_state_type;

   function automatic rsp_slot_type mk_slot(logic [31:0] word, logic is_reg, logic err);
      rsp_slot_type s;
      s.word        = word;
      s.is_register = is_reg;
      s.error       = err;
      return s;
   endfunction

   // address in 24:16, data in 15:0 of a 27-bit register field
   function automatic logic [31:0] reg_word(logic [26:0] field);
      return {7'b0, field[24:16], field[15:0]};
   endfunction

endpackage

// ===== hdl/rwcd_chan_state.sv =====
module rwcd_chan_state (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [rwcd_pkg::ChanSelW-1:0]   sel,
   input  logic                            commit,
   input  rwcd_pkg::chan_state_type        wr_state,
   output rwcd_pkg::chan_state_type        rd_state
);

   logic [1:0]  half_count_ff  [rwcd_pkg::NumChannels];
   logic        frame_mode_ff  [rwcd_pkg::NumChannels];
   logic [47:0] held_halves_ff [rwcd_pkg::NumChannels];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < rwcd_pkg::NumChannels; i++) begin
            half_count_ff[i] <= '0;
            frame_mode_ff[i] <= 1'b0;
         end
      end else if (commit) begin
         half_count_ff[sel] <= wr_state.half_count;
         frame_mode_ff[sel] <= wr_state.frame_mode;
      end
   end

   // halves carry no reset, only what a channel stored is ever read
   always_ff @(posedge clock) begin
      if (commit) begin
         held_halves_ff[sel] <= wr_state.held_halves;
      end
   end

   assign rd_state.half_count  = half_count_ff[sel];
   assign rd_state.frame_mode  = frame_mode_ff[sel];
   assign rd_state.held_halves = held_halves_ff[sel];

endmodule

// ===== hdl/rwcd_decode.sv =====
module rwcd_decode (
   input  logic [31:0]                raw_word,
   input  logic                       chip_type,
   input  logic [15:0]                channel_enable,
   input  rwcd_pkg::chan_state_type   cur_state,
   output logic                       state_we,
   output rwcd_pkg::chan_state_type   nxt_state,
   output rwcd_pkg::rsp_set_type      rsp_set
);

   logic [3:0]  tag;
   logic [3:0]  ch;
   logic [15:0] cur;
   logic        tag_hit;
   logic        in_range;
   logic        enabled;
   logic        mode_eff;
   logic [15:0] h0;
   logic [15:0] h1;
   logic [15:0] h2;
   logic [31:0] b0;
   logic [59:0] b1;
   logic [26:0] d1;
   logic [26:0] d0;
   logic [7:0]  kword;

   assign tag      = raw_word[31:28];
   assign ch       = raw_word[23:20];
   assign cur      = raw_word[15:0];
   assign tag_hit  = (tag == rwcd_pkg::TagTrigger) ||
                     ((tag >= rwcd_pkg::TagTdcLo) && (tag <= rwcd_pkg::TagTdcHi));
   assign in_range = ({1'b0, ch} < 5'(rwcd_pkg::NumChannels));
   assign enabled  = in_range && channel_enable[ch];

   // group mode is fixed by its first word
   assign mode_eff = (cur_state.half_count == 2'd0) ? (raw_word[27:24] == rwcd_pkg::TagUserK)
                                                    : cur_state.frame_mode;

   assign h0 = cur_state.held_halves[47:32];
   assign h1 = cur_state.held_halves[31:16];
   assign h2 = cur_state.held_halves[15:0];
   assign b0 = {h2, cur};
   assign b1 = {h0[11:0], h1, h2, cur};

   // user-k field split for both front-end formats
   always_comb begin
      if (chip_type) begin
         d1    = {1'b0, b1[59:34]};
         d0    = b1[34:8];
         kword = b1[7:0];
      end else begin
         d1    = b0[28:2];
         d0    = {1'b0, cur[1:0], h0, h1[15:8]};
         kword = h1[7:0];
      end
   end

   always_comb begin
      rsp_set         = '0;
      rsp_set.channel = ch;
      state_we        = 1'b0;
      nxt_state       = cur_state;
      if (tag_hit) begin
         rsp_set.count    = 3'd1;
         rsp_set.slots[0] = rwcd_pkg::mk_slot(raw_word, 1'b0, 1'b1);
      end else if (enabled) begin
         state_we             = 1'b1;
         nxt_state.frame_mode = mode_eff;
         if (!mode_eff && !chip_type && (cur_state.half_count != 2'd0)) begin
            rsp_set.count        = 3'd1;
            rsp_set.slots[0]     = rwcd_pkg::mk_slot({h2, cur}, 1'b0, 1'b0);
            nxt_state.half_count = 2'd0;
         end else if (cur_state.half_count == 2'd3) begin
            nxt_state.half_count = 2'd0;
            if (mode_eff) begin
               unique case (kword)
                  rwcd_pkg::KBoth: begin
                     rsp_set.count    = 3'd4;
                     rsp_set.slots[0] = rwcd_pkg::mk_slot(rwcd_pkg::RegMarker, 1'b1, 1'b0);
                     rsp_set.slots[1] = rwcd_pkg::mk_slot(rwcd_pkg::reg_word(d1), 1'b1, 1'b0);
                     rsp_set.slots[2] = rwcd_pkg::mk_slot(rwcd_pkg::RegMarker, 1'b1, 1'b0);
                     rsp_set.slots[3] = rwcd_pkg::mk_slot(rwcd_pkg::reg_word(d0), 1'b1, 1'b0);
                  end
                  rwcd_pkg::KData1: begin
                     rsp_set.count    = 3'd2;
                     rsp_set.slots[0] = rwcd_pkg::mk_slot(rwcd_pkg::RegMarker, 1'b1, 1'b0);
                     rsp_set.slots[1] = rwcd_pkg::mk_slot(rwcd_pkg::reg_word(d1), 1'b1, 1'b0);
                  end
                  rwcd_pkg::KData0: begin
                     rsp_set.count    = 3'd2;
                     rsp_set.slots[0] = rwcd_pkg::mk_slot(rwcd_pkg::RegMarker, 1'b1, 1'b0);
                     rsp_set.slots[1] = rwcd_pkg::mk_slot(rwcd_pkg::reg_word(d0), 1'b1, 1'b0);
                  end
                  default: begin
                     rsp_set.count = 3'd0;
                  end
               endcase
            end else begin
               rsp_set.count    = 3'd2;
               rsp_set.slots[0] = rwcd_pkg::mk_slot({h0, h1}, 1'b0, 1'b0);
               rsp_set.slots[1] = rwcd_pkg::mk_slot({h2, cur}, 1'b0, 1'b0);
            end
         end else begin
            nxt_state.held_halves = {cur_state.held_halves[31:0], cur};
            nxt_state.half_count  = cur_state.half_count + 2'd1;
         end
      end
   end

endmodule

// ===== hdl/rwcd_rsp_buf.sv =====
`include "readout_word_channel_deframer_unit_macros.svh"

module rwcd_rsp_buf (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    load,
   input  rwcd_pkg::rsp_set_type   rsp_set,
   input  logic                    rsp_tready,
   output logic                    rsp_tvalid,
   output logic                    can_load,
   output logic [3:0]              channel,
   output logic [31:0]             word,
   output logic                    is_register,
   output logic                    error,
   output logic                    last
);

   rwcd_pkg::rsp_slot_type [3:0] slots_ff;
   rwcd_pkg::rsp_slot_type [3:0] slots_in;
   logic [2:0]                   rem_ff;
   logic [2:0]                   rem_in;
   logic [3:0]                   channel_ff;
   logic                         take;

   assign rsp_tvalid  = (rem_ff != 3'd0);
   assign take        = rsp_tvalid && rsp_tready;
   assign last        = (rem_ff == 3'd1);
   assign can_load    = (rem_ff == 3'd0) || (last && take);
   assign channel     = channel_ff;
   assign word        = slots_ff[0].word;
   assign is_register = slots_ff[0].is_register;
   assign error       = slots_ff[0].error;

   always_comb begin
      slots_in = slots_ff;
      rem_in   = rem_ff;
      if (load) begin
         slots_in = rsp_set.slots;
         rem_in   = rsp_set.count;
      end else if (take) begin
         slots_in = {slots_ff[3], slots_ff[3:1]};
         rem_in   = rem_ff - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff <= '0;
      end else begin
         rem_ff <= rem_in;
      end
   end

   always_ff @(posedge clock) begin
      slots_ff <= slots_in;
      if (load) begin
         channel_ff <= rsp_set.channel;
      end
   end

   `RWCD_ASSERT(a_rem_bound, rem_ff <= 3'd4, "result count above four")
   `RWCD_IMPLY(a_error_single, rsp_tvalid && error, last, "error result not alone")
   `RWCD_IMPLY(a_marker_not_last, rsp_tvalid && is_register && (word == rwcd_pkg::RegMarker),
      !last, "register marker without its address word")
   `RWCD_NEXT(a_drain, take && last && !load, !rsp_tvalid, "result shown after drain")

endmodule

// ===== hdl/readout_word_channel_deframer_unit.sv =====
// Readout word deframer: takes one 32-bit readout word per request and splits it by channel
// (bits 23:20). Trigger and time tags come out at once as a single error result. Enabled
// channels collect 16-bit halves; a data group gives one word from two halves (chip type 0)
// or two words from four halves (chip type 1), and a user-K group of four words gives zero,
// one or two register reads, each as marker 0x55000000 then address and data. Results of a
// request leave one per cycle while rsp_tready is high, with tlast on the final one; a request
// passes the input register and then the result register, which presents the first result.
// With results taken at once, a request is taken every cycle while each causes at most one
// result; one that causes more holds the single result register until its last result is
// taken. Per-channel state sits in flip-flops and is updated as a request leaves the input
// register. Configuration must be written only while the block is idle; it is not enforced.
module readout_word_channel_deframer_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // raw_word
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // channel[3:0], word[35:4], zero[39:36]
   output logic [1:0]  rsp_tuser,   // is_register[0], error[1]
   output logic        rsp_tlast,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata
);

   logic                       chip_type_ff;
   logic [15:0]                chan_enable_ff;
   logic                       in_valid_ff;
   logic [31:0]                in_word_ff;
   logic                       move;
   logic                       can_load;
   logic                       state_we;
   rwcd_pkg::chan_state_type   cur_state;
   rwcd_pkg::chan_state_type   nxt_state;
   rwcd_pkg::rsp_set_type      rsp_set;
   logic [3:0]                 out_channel;
   logic [31:0]                out_word;
   logic                       out_is_register;
   logic                       out_error;

   always_ff @(posedge clock) begin
      if (reset) begin
         chip_type_ff   <= 1'b0;
         chan_enable_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            rwcd_pkg::CsrChipType:   chip_type_ff   <= csr_wdata[0];
            rwcd_pkg::CsrChanEnable: chan_enable_ff <= csr_wdata;
         endcase
      end
   end

   assign move       = in_valid_ff && can_load;
   assign req_tready = !in_valid_ff || move;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tvalid && req_tready) begin
         in_valid_ff <= 1'b1;
      end else if (move) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_word_ff <= req_tdata;
      end
   end

   rwcd_chan_state u_state (
      .clock    (clock),
      .reset    (reset),
      .sel      (in_word_ff[20 +: rwcd_pkg::ChanSelW]),
      .commit   (move && state_we),
      .wr_state (nxt_state),
      .rd_state (cur_state)
   );

   rwcd_decode u_decode (
      .raw_word       (in_word_ff),
      .chip_type      (chip_type_ff),
      .channel_enable (chan_enable_ff),
      .cur_state      (cur_state),
      .state_we       (state_we),
      .nxt_state      (nxt_state),
      .rsp_set        (rsp_set)
   );

   rwcd_rsp_buf u_rsp_buf (
      .clock       (clock),
      .reset       (reset),
      .load        (move),
      .rsp_set     (rsp_set),
      .rsp_tready  (rsp_tready),
      .rsp_tvalid  (rsp_tvalid),
      .can_load    (can_load),
      .channel     (out_channel),
      .word        (out_word),
      .is_register (out_is_register),
      .error       (out_error),
      .last        (rsp_tlast)
   );

   assign rsp_tdata = {4'b0, out_word, out_channel};
   assign rsp_tuser = {out_error, out_is_register};

endmodule
